// File: hdl/rstb_pkg.sv
// ----------------------------------------------------------------------------
// rstb_pkg: shared types and constants for the repeating soft timer bank
// Sizes of the timer bank, item codes, sequencer states and the timer entry.
// ----------------------------------------------------------------------------
package rstb_pkg;

  // Bank geometry
  localparam int NUM_TIMERS = 8;
  localparam int MASK_W     = 8;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int SLOT_W     = 7;
  localparam int TICK_W     = 32;
  localparam int CNT_W      = 16;
  localparam int SEL_W      = 3;

  // Repeat count codes
  localparam logic [CNT_W-1:0] FOREVER_COUNT  = 16'hFFFF;
  localparam logic [CNT_W-1:0] DISABLED_COUNT = 16'h0000;

  // Item kinds carried in tuser
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_START   = 2'd1,
    OP_SERVICE = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  // One timer slot
  typedef struct packed {
    logic [TICK_W-1:0] ticks;
    logic [TICK_W-1:0] reload;
    logic [CNT_W-1:0]  firings;
    logic              expired;
  } timer_t;

  // Sequencer to datapath control
  typedef struct packed {
    logic             ready;
    logic             sweep;
    logic [IDX_W-1:0] idx;
    logic             load_out;
  } seq_ctrl_t;

endpackage

// File: hdl/rstb_unit.sv
// ----------------------------------------------------------------------------
// rstb_unit: shared timer update unit
// Applies one tick or one service step to a single timer slot per cycle.
// ----------------------------------------------------------------------------
module rstb_unit
  import rstb_pkg::*;
(
  input  op_t    op,
  input  timer_t cur,
  output timer_t upd,
  output logic   fire
);

  logic enabled;
  logic forever_cnt;

  assign enabled     = (cur.firings != DISABLED_COUNT);
  assign forever_cnt = (cur.firings == FOREVER_COUNT);

  // Compute the updated slot and its fire bit
  always_comb begin
    upd  = cur;
    fire = 1'b0;
    case (op)
      OP_TICK: begin
        if (enabled) begin
          if (cur.ticks > TICK_W'(1)) begin
            upd.ticks = cur.ticks - TICK_W'(1);
          end else begin
            upd.expired = 1'b1;
          end
        end
      end
      OP_SERVICE: begin
        if (cur.expired) begin
          upd.expired = 1'b0;
          if (!enabled) begin
            upd.ticks = '0;
          end else begin
            if (!forever_cnt) begin
              upd.firings = cur.firings - CNT_W'(1);
            end
            upd.ticks = cur.reload;
            fire      = 1'b1;
          end
        end
      end
      default: begin
        upd  = cur;
        fire = 1'b0;
      end
    endcase
  end

endmodule

// File: hdl/rstb_seq.sv
// ----------------------------------------------------------------------------
// rstb_seq: sweep sequencer
// Walks the slot index over the bank for tick and service items and hands
// the finished result to the output register.
// ----------------------------------------------------------------------------
module rstb_seq
  import rstb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  op_t       op,
  input  logic      out_free,
  output seq_ctrl_t ctrl
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

  state_t           state, state_next;
  logic [IDX_W-1:0] idx, idx_next;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (op == OP_TICK || op == OP_SERVICE) begin
            state_next = ST_SWEEP;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_SWEEP: begin
        if (idx == LAST_IDX) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Advance the slot index during a sweep, wrap at the end
  always_comb begin
    idx_next = idx;
    if (state == ST_SWEEP) begin
      idx_next = (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
    end
  end

  // Outputs
  always_comb begin
    ctrl.ready    = (state == ST_IDLE);
    ctrl.sweep    = (state == ST_SWEEP);
    ctrl.idx      = idx;
    ctrl.load_out = (state == ST_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule

// File: hdl/repeating_soft_timer_bank.sv
// ----------------------------------------------------------------------------
// repeating_soft_timer_bank: bank of repeating software timers
// Start, tick and service items act on a bank of timers; every item returns
// the fire and pending masks.
//
//   channel  | dir | tdata                                    | tuser
//   ---------+-----+------------------------------------------+-----------
//   s_axis   | in  | timer_index, period, repeat_count        | op
//   m_axis   | out | fire_mask, pending_mask                  | -
//
// Tick and service items sweep the bank through one shared update unit, one
// slot per cycle: the result is loaded into the output register after the last
// slot, and the next item is taken once the sequencer is back in idle.
// Start items and the unused code skip the sweep and go straight to the finish state.
// A result waits in the output register; the next item is taken while it waits.
// Synchronous reset clears every timer (disabled, not pending) and the channels.
// ----------------------------------------------------------------------------
module repeating_soft_timer_bank
  import rstb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] timer_index, [34:3] period, [50:35] repeat_count, [55:51] zero
  input  logic [55:0] s_axis_tdata,
  // [1:0] op
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] fire_mask, [15:8] pending_mask
  output logic [15:0] m_axis_tdata
);

  seq_ctrl_t          ctrl;
  logic               accept;
  logic               out_free;
  op_t                in_op;
  op_t                op_q;
  logic [SEL_W-1:0]   timer_index;
  logic [TICK_W-1:0]  period;
  logic [CNT_W-1:0]   repeat_count;
  logic [SLOT_W-1:0]  slot_ext;
  logic [IDX_W-1:0]   slot;
  logic               slot_ok;
  timer_t             timers [NUM_TIMERS];
  timer_t             cur;
  timer_t             upd;
  logic               fire;
  logic [MASK_W-1:0]  fire_acc;
  logic [MASK_W-1:0]  pend_mask;

  // Unpack the input transaction
  assign in_op        = op_t'(s_axis_tuser);
  assign timer_index  = s_axis_tdata[2:0];
  assign period       = s_axis_tdata[34:3];
  assign repeat_count = s_axis_tdata[50:35];
  assign slot_ext     = SLOT_W'(timer_index);
  assign slot         = slot_ext[IDX_W-1:0];
  assign slot_ok      = (slot_ext < SLOT_W'(NUM_TIMERS));

  assign s_axis_tready = ctrl.ready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  rstb_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .op       (in_op),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  assign cur = timers[ctrl.idx];

  rstb_unit u_unit (
    .op   (op_q),
    .cur  (cur),
    .upd  (upd),
    .fire (fire)
  );

  // Pending mask from the flags of the low slots
  always_comb begin
    pend_mask = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (i < NUM_TIMERS) begin
        pend_mask[i] = timers[i].expired;
      end
    end
  end

  // Hold the item kind for the sweep
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q <= in_op;
    end
  end

  // Timer slots: start writes one slot, the sweep writes back the unit result
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        timers[i] <= '0;
      end
    end else if (accept && in_op == OP_START && slot_ok) begin
      timers[slot].ticks   <= period;
      timers[slot].reload  <= period;
      timers[slot].firings <= repeat_count;
    end else if (ctrl.sweep) begin
      timers[ctrl.idx] <= upd;
    end
  end

  // Collect fire bits over the sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      fire_acc <= '0;
    end else if (accept) begin
      fire_acc <= '0;
    end else if (ctrl.sweep && fire) begin
      for (int i = 0; i < MASK_W; i++) begin
        if (i < NUM_TIMERS && ctrl.idx == IDX_W'(i)) begin
          fire_acc[i] <= 1'b1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctrl.load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      m_axis_tdata <= {pend_mask, fire_acc};
    end
  end

endmodule

// File: bench/repeating_soft_timer_bank_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// repeating_soft_timer_bank_test: self-checking bench for the timer bank
// Drives tick, start, service and unused items over the input stream. A
// local model of the eight timers predicts the fire and pending masks of each
// transaction. Every output transaction is checked against the oldest
// prediction. Directed cases come first, then a long receiver stall and a
// long random run. Both stream sides insert random idle cycles.
// ----------------------------------------------------------------------------
module repeating_soft_timer_bank_test
  import rstb_pkg::*;
;

  typedef struct {
    logic [MASK_W-1:0] fire;
    logic [MASK_W-1:0] pending;
  } masks_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // [2:0] timer_index, [34:3] period, [50:35] repeat_count, [55:51] zero
  logic [55:0] s_axis_tdata;
  // [1:0] op
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [7:0] fire_mask, [15:8] pending_mask
  logic [15:0] m_axis_tdata;

  // Local copy of the timer bank
  logic [TICK_W-1:0] timer_ticks   [NUM_TIMERS];
  logic [TICK_W-1:0] timer_reload  [NUM_TIMERS];
  logic [CNT_W-1:0]  timer_firings [NUM_TIMERS];
  logic              timer_pending [NUM_TIMERS];

  masks_t mask_q[$];

  int errors          = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int fires_seen      = 0;
  bit send_idle       = 0;
  bit recv_idle       = 0;
  int hold_cycles_req = 0;

  repeating_soft_timer_bank i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop
  initial begin
    #2_000_000;
    $display("%0t: timeout, %0d results still expected", $realtime, mask_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Apply one transaction to the local bank and return the expected masks
  function automatic masks_t apply_timer_item(op_t op, logic [2:0] idx,
                                              logic [TICK_W-1:0] period,
                                              logic [CNT_W-1:0] count);
    masks_t m;
    m.fire = '0;
    m.pending = '0;
    case (op)
      OP_TICK: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (timer_firings[i] != DISABLED_COUNT) begin
            if (timer_ticks[i] > 1) timer_ticks[i] = timer_ticks[i] - TICK_W'(1);
            else timer_pending[i] = 1'b1;
          end
        end
      end
      OP_START: begin
        if (idx < NUM_TIMERS) begin
          timer_ticks[idx]   = period;
          timer_reload[idx]  = period;
          timer_firings[idx] = count;
        end
      end
      OP_SERVICE: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (timer_pending[i]) begin
            timer_pending[i] = 1'b0;
            if (timer_firings[i] == DISABLED_COUNT) begin
              timer_ticks[i] = '0;
            end else begin
              if (timer_firings[i] != FOREVER_COUNT)
                timer_firings[i] = timer_firings[i] - CNT_W'(1);
              timer_ticks[i] = timer_reload[i];
              if (i < MASK_W) m.fire[i] = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < NUM_TIMERS && i < MASK_W; i++)
      m.pending[i] = timer_pending[i];
    return m;
  endfunction

  // Offer one transaction and predict its masks once it is accepted
  task automatic send_item(op_t op, logic [2:0] idx, logic [TICK_W-1:0] period,
                           logic [CNT_W-1:0] count);
    int gap;
    gap = send_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, count, period, idx};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    mask_q.push_back(apply_timer_item(op, idx, period, count));
    items_sent++;
  endtask

  // Random transaction, mostly short periods so timers really expire
  task automatic send_random_item();
    int pick;
    int sel;
    op_t op;
    logic [2:0] idx;
    logic [TICK_W-1:0] period;
    logic [CNT_W-1:0] count;
    pick   = $urandom_range(0, 99);
    idx    = 3'($urandom);
    period = $urandom;
    count  = CNT_W'($urandom);
    if (pick < 40) begin
      op = OP_TICK;
    end else if (pick < 62) begin
      op = OP_START;
      if ($urandom_range(0, 9) != 0) period = $urandom_range(0, 6);
      sel = $urandom_range(0, 9);
      if (sel == 0) count = DISABLED_COUNT;
      else if (sel == 1) count = FOREVER_COUNT;
      else if (sel > 2) count = CNT_W'($urandom_range(1, 4));
    end else if (pick < 95) begin
      op = OP_SERVICE;
    end else begin
      op = OP_UNUSED;
    end
    send_item(op, idx, period, count);
  endtask

  // Receiver: random gaps per transaction, plus a long hold on request
  initial begin
    int gap;
    int n;
    m_axis_tready = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_cycles_req > 0) begin
        n = hold_cycles_req;
        hold_cycles_req = 0;
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      gap = recv_idle ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // Check each output transaction against the oldest prediction
  always @(posedge clk) begin
    masks_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (mask_q.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, m_axis_tdata);
        errors++;
      end else begin
        want = mask_q.pop_front();
        results_checked++;
        if (m_axis_tdata[7:0] != 0) fires_seen++;
        if (m_axis_tdata[7:0] !== want.fire) begin
          $display("%0t: fire_mask expected %h actual %h",
                   $realtime, want.fire, m_axis_tdata[7:0]);
          errors++;
        end
        if (m_axis_tdata[15:8] !== want.pending) begin
          $display("%0t: pending_mask expected %h actual %h",
                   $realtime, want.pending, m_axis_tdata[15:8]);
          errors++;
        end
      end
    end
  end

  // Empty bank: nothing counts, nothing fires
  task automatic test_idle_bank();
    send_item(OP_TICK, 3'd0, '0, '0);
    send_item(OP_SERVICE, 3'd0, '0, '0);
    send_item(OP_UNUSED, 3'd0, '0, '0);
  endtask

  // Single firing: pend, fire once, then the timer goes quiet
  task automatic test_single_shot();
    send_item(OP_START, 3'd0, 32'd1, 16'd1);
    send_item(OP_TICK, 3'd0, '0, '0);
    send_item(OP_SERVICE, 3'd0, '0, '0);
    send_item(OP_TICK, 3'd0, '0, '0);
  endtask

  // Forever count, zero and all-ones periods, top slot
  task automatic test_forever_and_extremes();
    send_item(OP_START, 3'd7, 32'd0, FOREVER_COUNT);
    send_item(OP_START, 3'd3, 32'hFFFF_FFFF, 16'hFFFE);
    send_item(OP_TICK, 3'd0, '0, '0);
    send_item(OP_SERVICE, 3'd0, '0, '0);
    send_item(OP_TICK, 3'd0, '0, '0);
    send_item(OP_SERVICE, 3'd0, '0, '0);
  endtask

  // A restart with count zero keeps the flag; service then clears it without firing
  task automatic test_start_keeps_pending();
    send_item(OP_START, 3'd5, 32'd2, 16'd2);
    send_item(OP_TICK, 3'd0, '0, '0);
    send_item(OP_TICK, 3'd0, '0, '0);
    send_item(OP_START, 3'd5, 32'd3, DISABLED_COUNT);
    send_item(OP_SERVICE, 3'd0, '0, '0);
  endtask

  // Unused code with every field bit set changes nothing
  task automatic test_unused_code();
    send_item(OP_START, 3'd1, 32'd1, 16'd3);
    send_item(OP_TICK, 3'd0, '0, '0);
    send_item(OP_UNUSED, 3'd7, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(OP_SERVICE, 3'd0, '0, '0);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  task automatic test_output_stall();
    send_idle = 0;
    recv_idle = 0;
    hold_cycles_req = 150;
    repeat (30) send_random_item();
  endtask

  // Long random run in stretches with and without idle cycles
  task automatic test_random_mix(int num_items);
    for (int k = 0; k < num_items; k++) begin
      if (k % 50 == 0) begin
        send_idle = $urandom_range(0, 2) != 0;
        recv_idle = $urandom_range(0, 2) != 0;
      end
      send_random_item();
    end
  endtask

  // Test sequence
  initial begin
    int wait_cnt;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      timer_ticks[i]   = '0;
      timer_reload[i]  = '0;
      timer_firings[i] = DISABLED_COUNT;
      timer_pending[i] = 1'b0;
    end
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_TICK;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_idle = 1;
    recv_idle = 1;
    test_idle_bank();
    test_single_shot();
    test_forever_and_extremes();
    test_start_keeps_pending();
    test_unused_code();
    test_output_stall();
    test_random_mix(700);
    s_axis_tvalid <= 1'b0;

    // Drain the outstanding results
    wait_cnt = 0;
    while (mask_q.size() != 0 && wait_cnt < 5000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (20) @(posedge clk);
    if (mask_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $realtime, mask_q.size());
      errors++;
    end

    $display("Sent %0d items (tick, start, service, unused), checked %0d results,",
             items_sent, results_checked);
    $display("%0d of them with timers firing; %0d mismatches.", fires_seen, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
